@@ design/cs2rgb_pkg.sv @@
`default_nettype none
package cs2rgb_pkg;

	localparam int FRAC   = 16;
	localparam int GDEPTH = 1024;
	localparam int GW     = $clog2(GDEPTH + 1);
	localparam int EW     = FRAC + 2;
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [15:0] ch0_high_word;
		logic [7:0]  ch0_low_byte;
		logic [15:0] ch1_high_word;
		logic [7:0]  ch1_low_byte;
		logic [15:0] ch2_high_word;
		logic [7:0]  ch2_low_byte;
		logic [15:0] ch3_high_word;
		logic [7:0]  ch3_low_byte;
	} reading_t;

	typedef struct packed {
		logic signed [39:0] x_value;
		logic signed [39:0] y_value;
		logic signed [39:0] z_value;
		logic [40:0]        lux_value;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} result_t;

	// saturated ADC codes of channels 0..2 (channel 3 carries zero weight)
	typedef struct packed {
		logic [2:0][31:0] code;
	} codes_t;

	typedef struct packed {
		logic [127:0] q;
		logic [63:0]  r;
	} divres_t;

	typedef logic signed [EW-1:0] gtab_t [0:GDEPTH];
	typedef logic [7:0] ltab_t [0:255];

	// restoring long division, elaboration only
	function automatic divres_t udiv(input logic [127:0] n, input logic [63:0] d);
		divres_t res;
		logic [64:0] r;
		res.q = '0;
		r = '0;
		for (int i = 127; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				res.q[i] = 1'b1;
			end
		end
		res.r = r[63:0];
		return res;
	endfunction

	// round(num * 2^shift / den)
	function automatic logic signed [63:0] fix_const(input longint num, input logic [63:0] den,
			input int shift);
		logic [63:0] mag;
		logic [63:0] q;
		divres_t dr;
		mag = (num < 0) ? 64'(-num) : 64'(num);
		dr = udiv({64'd0, mag} << shift, den);
		q = dr.q[63:0];
		if ({dr.r, 1'b0} >= {1'b0, den})
			q = q + 64'd1;
		return (num < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic longint xyz_num(input int r, input int c);
		longint v;
		case (r * 3 + c)
			0: v = 64'sd2348929920;
			1: v = 64'sd407467441;
			2: v = 64'sd928619404;
			3: v = -64'sd189652390;
			4: v = 64'sd1989582020;
			5: v = -64'sd169739553;
			6: v = 64'sd120811684;
			7: v = -64'sd158848115;
			8: v = 64'sd6740215200;
			default: v = 0;
		endcase
		return v;
	endfunction

	function automatic longint rgb_num(input int r, input int c);
		longint v;
		case (r * 3 + c)
			0: v = 32406;
			1: v = -15372;
			2: v = -4986;
			3: v = -9689;
			4: v = 18758;
			5: v = 415;
			6: v = 557;
			7: v = -2040;
			8: v = 10570;
			default: v = 0;
		endcase
		return v;
	endfunction

	localparam logic [63:0] XYZ_DEN = 64'd10000000000000;
	localparam logic [63:0] RGB_DEN = 64'd1000000;
	localparam logic [31:0] LUX_W   = 32'(fix_const(64'sd21500000000, XYZ_DEN, 40));
	localparam logic [7:0]  THRESH  = 8'(fix_const(64'sd31308, 64'd10000000, FRAC));

	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x, r, b;
		x = xin;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] icbrt64(input logic [63:0] xin);
		logic [63:0] x, y, b;
		x = xin;
		y = '0;
		for (int s = 63; s >= 0; s -= 3) begin
			y = y << 1;
			b = 64'd3 * y * (y + 64'd1) + 64'd1;
			if ((x >> s) >= b) begin
				x = x - (b << s);
				y = y + 64'd1;
			end
		end
		return y;
	endfunction

	function automatic logic signed [63:0] gamma_entry(input int k);
		divres_t dr, dr2;
		logic [63:0] v, s1, s2, w, h, p4, y;
		logic signed [63:0] num, g;
		dr  = udiv(128'(k) << 40, 64'(GDEPTH));
		dr2 = udiv({64'd0, dr.r} << 20, 64'(GDEPTH));
		v  = (dr.q[63:0] << 20) + dr2.q[63:0];
		s1 = isqrt64(v);
		s2 = isqrt64(s1 << 30);
		w  = icbrt64(s2 << 30);
		h  = (w * w) >> 10;
		p4 = (h * h) >> 30;
		y  = (p4 * w) >> 20;
		num = $signed(64'd1055 * y) - (64'sd55 <<< 30);
		if (num >= 0) begin
			dr = udiv({64'd0, num}, 64'd1000);
			g = $signed(dr.q[63:0]);
		end else begin
			dr = udiv({64'd0, -num + 64'sd999}, 64'd1000);
			g = -$signed(dr.q[63:0]);
		end
		return g >>> (30 - FRAC);
	endfunction

	function automatic gtab_t build_gtab();
		gtab_t t;
		for (int k = 0; k <= GDEPTH; k++)
			t[k] = EW'(gamma_entry(k));
		return t;
	endfunction

	// linear segment: floor(lin * 255 * 12.92 / 2^FRAC) for small lin
	function automatic ltab_t build_ltab();
		ltab_t t;
		divres_t dr;
		for (int i = 0; i < 256; i++) begin
			dr = udiv(128'(i) * 128'd32946, 64'(10 * (1 << FRAC)));
			t[i] = 8'(dr.q);
		end
		return t;
	endfunction

endpackage
`default_nettype wire

@@ design/cs2rgb_front.sv @@
`default_nettype none
module cs2rgb_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire cs2rgb_pkg::reading_t reading,
	input  wire logic                 q_almost_full,
	output logic                      busy,
	output logic                      push,
	output cs2rgb_pkg::codes_t        wdata
);

	logic [2:0][15:0] hi;
	logic [2:0][7:0]  lo;
	cs2rgb_pkg::codes_t codes;
	logic v_s1;
	cs2rgb_pkg::codes_t codes_s1;

	assign hi = {reading.ch2_high_word, reading.ch1_high_word, reading.ch0_high_word};
	assign lo = {reading.ch2_low_byte, reading.ch1_low_byte, reading.ch0_low_byte};

	// mantissa << exponent, saturate at 2^32-1
	always_comb begin
		logic [34:0] c;
		for (int n = 0; n < 3; n++) begin
			c = 35'({hi[n][11:0], lo[n]}) << hi[n][15:12];
			codes.code[n] = (c[34:32] != 3'd0) ? 32'hFFFF_FFFF : c[31:0];
		end
	end

	assign busy = q_almost_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			codes_s1 <= codes;
		end
	end

	assign push  = v_s1;
	assign wdata = codes_s1;

endmodule
`default_nettype wire

@@ design/cs2rgb_queue.sv @@
`default_nettype none
module cs2rgb_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire cs2rgb_pkg::codes_t wdata,
	input  wire logic               pop,
	output logic                    rvalid,
	output cs2rgb_pkg::codes_t      rdata,
	output logic                    almost_full
);

	localparam int PW = $clog2(cs2rgb_pkg::QDEPTH);
	localparam int CW = $clog2(cs2rgb_pkg::QDEPTH + 1);

	cs2rgb_pkg::codes_t mem_q [cs2rgb_pkg::QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic do_pop;

	assign rvalid = count_q != '0;
	assign rdata  = mem_q[rptr_q];
	assign do_pop = pop && rvalid;
	// leave room for the beat already in the front register
	assign almost_full = count_q >= CW'(cs2rgb_pkg::QDEPTH - 1);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + PW'(1);
			if (do_pop)
				rptr_q <= rptr_q + PW'(1);
			if (push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (!push && do_pop)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

@@ design/cs2rgb_back.sv @@
`default_nettype none
module cs2rgb_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire cs2rgb_pkg::codes_t q_data,
	output logic                    pop,
	output cs2rgb_pkg::result_t     result,
	output logic                    result_valid
);

	localparam int FRAC = cs2rgb_pkg::FRAC;
	localparam int EW   = cs2rgb_pkg::EW;
	localparam int GW   = cs2rgb_pkg::GW;
	localparam cs2rgb_pkg::gtab_t GTAB = cs2rgb_pkg::build_gtab();
	localparam cs2rgb_pkg::ltab_t LTAB = cs2rgb_pkg::build_ltab();

	localparam logic [1:0] CLS_ZERO  = 2'd0;
	localparam logic [1:0] CLS_LIN   = 2'd1;
	localparam logic [1:0] CLS_ONE   = 2'd2;
	localparam logic [1:0] CLS_CURVE = 2'd3;

	typedef struct packed {
		logic [2:0][39:0] xyz;
		logic [40:0]      lux;
	} xyzl_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [63:0] xprod_s1 [3][3];
	logic [63:0]        luxp_s1;
	xyzl_t              xl_s2, xl_s3, xl_s4, xl_s5, xl_s6;

	logic signed [57:0] rprod_s3 [3][3];
	logic signed [39:0] lin_s4 [3];
	logic [1:0]         cls_s4 [3], cls_s5 [3], cls_s6 [3];
	logic signed [EW-1:0] e0_s5 [3], e1_s5 [3];
	logic [FRAC-1:0]    f_s5 [3];
	logic [7:0]         lo_s5 [3], lo_s6 [3];
	logic signed [EW:0] g_s6 [3];
	logic [7:0]         rgb_s7 [3];
	xyzl_t              xl_s7;

	assign pop = q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// codes times tristimulus weights (Q40)
	for (genvar r = 0; r < 3; r++) begin : g_xyz
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam logic signed [31:0] XW = 32'(cs2rgb_pkg::fix_const(
				cs2rgb_pkg::xyz_num(r, c), cs2rgb_pkg::XYZ_DEN, 40));
			localparam logic signed [17:0] RW = 18'(cs2rgb_pkg::fix_const(
				cs2rgb_pkg::rgb_num(r, c), cs2rgb_pkg::RGB_DEN, 20));
			always_ff @(posedge clk) begin
				xprod_s1[r][c] <= 64'($signed({1'b0, q_data.code[c]}) * XW);
				rprod_s3[r][c] <= 58'($signed(xl_s2.xyz[c]) * RW);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] s;
		luxp_s1 <= 64'(q_data.code[1]) * 64'(cs2rgb_pkg::LUX_W);
		for (int r = 0; r < 3; r++) begin
			s = xprod_s1[r][0] + xprod_s1[r][1] + xprod_s1[r][2];
			xl_s2.xyz[r] <= s[63:24];
		end
		xl_s2.lux <= {1'b0, luxp_s1[63:24]};
		xl_s3 <= xl_s2;
		xl_s4 <= xl_s3;
		xl_s5 <= xl_s4;
		xl_s6 <= xl_s5;
		xl_s7 <= xl_s6;
	end

	for (genvar r = 0; r < 3; r++) begin : g_enc
		logic signed [59:0] rsum;
		logic signed [39:0] lin;
		logic [FRAC+GW-1:0] p;
		logic [GW-1:0]      idx;
		logic signed [EW:0] diff;
		logic signed [EW+FRAC+1:0] prod;
		logic signed [EW+9:0] t;
		logic signed [EW+9:0] sh;

		assign rsum = 60'(rprod_s3[r][0]) + 60'(rprod_s3[r][1]) + 60'(rprod_s3[r][2]);
		assign lin  = rsum[59:20];
		assign p    = (FRAC+GW)'(lin_s4[r][FRAC-1:0]) * (FRAC+GW)'(cs2rgb_pkg::GDEPTH);
		assign idx  = p[FRAC+GW-1:FRAC];
		assign diff = (EW+1)'(e1_s5[r]) - (EW+1)'(e0_s5[r]);
		assign prod = diff * $signed({1'b0, f_s5[r]});
		assign t    = ((EW+10)'(g_s6[r]) <<< 8) - (EW+10)'(g_s6[r]);
		assign sh   = t >>> FRAC;

		always_ff @(posedge clk) begin
			lin_s4[r] <= lin;
			if (lin <= 40'sd0)
				cls_s4[r] <= CLS_ZERO;
			else if (lin <= $signed({32'd0, cs2rgb_pkg::THRESH}))
				cls_s4[r] <= CLS_LIN;
			else if (lin >= (40'sd1 <<< FRAC))
				cls_s4[r] <= CLS_ONE;
			else
				cls_s4[r] <= CLS_CURVE;

			cls_s5[r] <= cls_s4[r];
			e0_s5[r]  <= GTAB[idx];
			e1_s5[r]  <= GTAB[idx + GW'(1)];
			f_s5[r]   <= p[FRAC-1:0];
			lo_s5[r]  <= LTAB[lin_s4[r][7:0]];

			cls_s6[r] <= cls_s5[r];
			lo_s6[r]  <= lo_s5[r];
			g_s6[r]   <= (EW+1)'(e0_s5[r]) + (EW+1)'(prod >>> FRAC);

			unique case (cls_s6[r])
				CLS_ZERO: rgb_s7[r] <= 8'd0;
				CLS_LIN:  rgb_s7[r] <= lo_s6[r];
				CLS_ONE:  rgb_s7[r] <= 8'd255;
				CLS_CURVE: begin
					if (sh < 0)
						rgb_s7[r] <= 8'd0;
					else if (sh > (EW+10)'(255))
						rgb_s7[r] <= 8'd255;
					else
						rgb_s7[r] <= sh[7:0];
				end
				default: rgb_s7[r] <= 8'd0;
			endcase
		end
	end

	assign result_valid     = v_s7;
	assign result.x_value   = xl_s7.xyz[0];
	assign result.y_value   = xl_s7.xyz[1];
	assign result.z_value   = xl_s7.xyz[2];
	assign result.lux_value = xl_s7.lux;
	assign result.red       = rgb_s7[0];
	assign result.green     = rgb_s7[1];
	assign result.blue      = rgb_s7[2];

endmodule
`default_nettype wire

@@ design/color_sensor_codes_to_srgb.sv @@
// Color sensor readout to CIE XYZ, lux and 8-bit sRGB.
//
// Input: a full four-channel reading (high word with exponent and mantissa
// top, low mantissa byte per channel) is taken on a rising edge with start
// high and busy low. One reading may be taken every cycle.
// Output: result_valid is high for exactly one cycle with X, Y, Z and lux in
// Q.16 and the gamma-encoded red, green and blue bytes on result.
//
// The front register and the queue lie ahead of the back end. Throughput is
// one reading per cycle, set by the fully pipelined back end (two multiplier
// stages, a sum stage, a classify stage, a gamma ROM read, interpolation and
// the final scale). The front computes the ADC codes and writes them into a
// four-entry queue that the back end drains every cycle, so busy stays low.
//
// Reset clears the queue and every valid stage; no result is issued until
// a reading arrives. The receiver cannot stall, so no result is ever held.
`default_nettype none
module color_sensor_codes_to_srgb (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire cs2rgb_pkg::reading_t reading,
	output logic                      busy,
	output cs2rgb_pkg::result_t       result,
	output logic                      result_valid
);

	logic push, pop, q_valid, q_almost_full;
	cs2rgb_pkg::codes_t wdata, q_data;

	cs2rgb_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .reading(reading),
		.q_almost_full(q_almost_full), .busy(busy), .push(push), .wdata(wdata)
	);

	cs2rgb_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wdata), .pop(pop),
		.rvalid(q_valid), .rdata(q_data), .almost_full(q_almost_full)
	);

	cs2rgb_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data), .pop(pop),
		.result(result), .result_valid(result_valid)
	);

endmodule
`default_nettype wire

@@ design/cs2rgb_chk.sv @@
`default_nettype none
module cs2rgb_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                result_valid,
	input wire cs2rgb_pkg::result_t result
);

	logic [3:0] pend_q;

	// count beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(start && !busy) - 4'(result_valid);
		end
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 4'd0)
		else $error("result strobe without a pending reading");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd9)
		else $error("too many readings in flight");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although the back end never stalls");

	a_lux_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.lux_value[40] == 1'b0)
		else $error("lux exceeds the product range");

endmodule

bind color_sensor_codes_to_srgb cs2rgb_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .result(result)
);
`default_nettype wire
